>>> hw/rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared types, constants and round functions for the byte stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } sha_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } sha_state_t;

  // controller to datapath
  typedef struct packed {
    logic put_in;     // write input byte
    logic put_pad;    // write padding byte (0x80 first, then zeros)
    logic put_len;    // write length words, clear fill
    logic round_init; // load round vars from hash
    logic round_step; // run one round
    logic fold;       // add round vars into hash
    logic out_shift;  // move to next digest word
    logic restart;    // reset hash and length for next message
  } sha_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       pad_first; // next pad byte is 0x80
    logic [5:0] fill;
    logic       last_round;
    logic       out_last;
  } sha_stat_t;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [5:0] LEN_FILL = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

>>> hw/rtl/sha256_byte_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Top level: controller plus datapath.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per message byte (byte_present) with message_end on
//           the final request; an end request may carry no byte.
//   out_* : eight digest word requests, H0 first, digest_last on H7.
// Sequence: a byte that does not complete a block is written and the block
//   stays ready. The 64th byte of a block starts 64 rounds of the single
//   round unit, then a fold into the hash. An end request pads one byte a
//   cycle up to byte 56, writes the length, runs 64 rounds and folds, then
//   offers the digest; a tail of 56 to 63 bytes adds one more block. The
//   compression loop runs one round per cycle and takes no input meanwhile.
// Reset: hash returns to the initial value, length and fill clear, the block
//   is idle and accepts a request.
// Stall: while the receiver holds out_ready low the digest word holds and no
//   input is taken; the hash is reset after the eighth word is taken.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_unit import sha_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sha_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sha_out_t out_data
);

  sha_cmd_t  cmd;
  sha_stat_t stat;

  sha_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .cmd(cmd), .stat(stat));

  sha_dpath u_dpath (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd), .stat(stat),
    .out_data(out_data));

endmodule

>>> hw/rtl/sha_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte intake, padding, 64 rounds per block and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl import sha_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sha_in_t   in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output sha_cmd_t  cmd,
  input  sha_stat_t stat
);

  sha_state_t state_r, state_nxt;
  logic       end_r, end_nxt;   // message end pending after current block
  logic       final_r, final_nxt; // block being compressed is the length block

  logic acc;
  assign acc = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    end_nxt   = end_r;
    final_nxt = final_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          end_nxt   = in_data.message_end;
          final_nxt = 1'b0;
          if (in_data.byte_present && stat.fill == 6'd63) state_nxt = ST_ROUND;
          else if (in_data.message_end) state_nxt = ST_PAD;
        end
      end
      ST_PAD: begin
        // 0x80 goes in first, then zeros up to the length slot
        if (stat.fill == LEN_FILL && !stat.pad_first) state_nxt = ST_LEN;
        else if (stat.fill == 6'd63) state_nxt = ST_ROUND;
      end
      ST_LEN: begin
        final_nxt = 1'b1;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (stat.last_round) state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        if (final_r) state_nxt = ST_OUT;
        else if (end_r) state_nxt = ST_PAD;
        else state_nxt = ST_IDLE;
      end
      ST_OUT: begin
        if (out_ready && stat.out_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.put_in = acc && in_data.byte_present;
        cmd.round_init = acc && in_data.byte_present && stat.fill == 6'd63;
      end
      ST_PAD: begin
        cmd.put_pad    = stat.pad_first || stat.fill != LEN_FILL;
        cmd.round_init = stat.fill == 6'd63;
      end
      ST_LEN: begin
        cmd.put_len    = 1'b1;
        cmd.round_init = 1'b1;
      end
      ST_ROUND: cmd.round_step = 1'b1;
      ST_FOLD:  cmd.fold = 1'b1;
      ST_OUT: begin
        out_valid     = 1'b1;
        cmd.out_shift = out_ready;
        cmd.restart   = out_ready && stat.out_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      end_r   <= 1'b0;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      end_r   <= end_nxt;
      final_r <= final_nxt;
    end
  end

endmodule

>>> hw/rtl/sha_dpath.sv
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer with rolling 16-word schedule, round unit, hash and length.
// ----------------------------------------------------------------------------
module sha_dpath import sha_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  sha_in_t   in_data,
  input  sha_cmd_t  cmd,
  output sha_stat_t stat,
  output sha_out_t  out_data
);

  logic [31:0] hash_r [8];
  logic [31:0] hash_nxt [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];   // word 0 is the current schedule word
  logic [63:0] len_r;
  logic [5:0]  fill_r;
  logic [5:0]  rnd_r;
  logic [2:0]  oidx_r;
  logic        pad_first_r; // next pad byte is 0x80

  // byte write position
  logic [7:0]  wbyte;
  logic        wen;
  logic [3:0]  wpos;
  logic [1:0]  bpos;
  assign wen  = cmd.put_in || cmd.put_pad;
  assign wbyte = cmd.put_in ? in_data.data_byte : (pad_first_r ? 8'h80 : 8'h00);
  assign wpos = fill_r[5:2];
  assign bpos = fill_r[1:0];

  // round arithmetic
  logic [31:0] s1, ch, s0, mj, t1, t2, wnew;
  always_comb begin
    s1 = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    s0 = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1 = v_r[7] + s1 + ch + ROUND_K[rnd_r] + w_r[0];
    t2 = s0 + mj;
    wnew = w_r[0] + sig0(w_r[1]) + w_r[9] + sig1(w_r[14]);
  end

  always_comb begin
    for (int i = 0; i < 8; i++) hash_nxt[i] = hash_r[i] + v_r[i];
  end

  // schedule buffer and round variables
  always_ff @(posedge clk) begin
    if (wen) begin
      if (bpos == 2'd0) w_r[wpos] <= {wbyte, 24'h0};
      else w_r[wpos] <= w_r[wpos] | ({24'h0, wbyte} << (5'd24 - {bpos, 3'b000}));
    end else if (cmd.put_len) begin
      w_r[14] <= len_r[63:32];
      w_r[15] <= len_r[31:0];
    end else if (cmd.round_step) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
      w_r[15] <= wnew;
    end
    if (cmd.round_init) begin
      for (int i = 0; i < 8; i++) v_r[i] <= hash_r[i];
    end else if (cmd.round_step) begin
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  // control state: hash, length, counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) hash_r[i] <= INIT_HASH[i];
      len_r <= '0; fill_r <= '0; rnd_r <= '0; oidx_r <= '0; pad_first_r <= 1'b1;
    end else begin
      if (wen) fill_r <= fill_r + 6'd1;
      if (cmd.put_len) fill_r <= '0;
      if (cmd.put_in) len_r <= len_r + 64'd8;
      if (cmd.put_pad) pad_first_r <= 1'b0;
      if (cmd.round_step) rnd_r <= rnd_r + 6'd1;
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) hash_r[i] <= hash_nxt[i];
      end
      if (cmd.out_shift) oidx_r <= oidx_r + 3'd1;
      if (cmd.restart) begin
        for (int i = 0; i < 8; i++) hash_r[i] <= INIT_HASH[i];
        len_r <= '0; pad_first_r <= 1'b1;
      end
    end
  end

  assign stat.pad_first  = pad_first_r;
  assign stat.fill       = fill_r;
  assign stat.last_round = (rnd_r == 6'd63);
  assign stat.out_last   = (oidx_r == 3'd7);
  assign out_data.digest_word = hash_r[oidx_r];
  assign out_data.digest_last = (oidx_r == 3'd7);

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Drives byte requests with random gaps and output stalls, predicts each
// digest with an independent SHA-256 model and checks every digest word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import sha_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  sha_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  sha_out_t out_data;

  sha256_byte_stream_hasher_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Predictor constants
  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] KTAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  // Predictor state
  logic [31:0] hash_acc [8];
  logic [7:0]  blk_bytes [64];
  logic [5:0]  blk_fill;
  logic [63:0] msg_bits;

  sha_out_t digest_q [$];
  int       mismatches;
  bit       stim_done;

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One compression of the buffered block into the running hash
  task automatic compress_blk();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hash_acc[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[r] + w[r];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_acc[i] = hash_acc[i] + v[i];
  endtask

  task automatic push_byte(logic [7:0] b);
    blk_bytes[blk_fill] = b;
    blk_fill = blk_fill + 6'd1;
  endtask

  // Apply one accepted request to the predictor
  task automatic hash_request(sha_in_t rq);
    sha_out_t d;
    if (rq.byte_present) begin
      push_byte(rq.data_byte);
      msg_bits = msg_bits + 64'd8;
      if (blk_fill == 6'd0) compress_blk();
    end
    if (rq.message_end) begin
      push_byte(8'h80);
      if (blk_fill > 6'd56 || blk_fill == 6'd0) begin
        while (blk_fill != 6'd0) push_byte(8'h00);
        compress_blk();
      end
      while (blk_fill < 6'd56) push_byte(8'h00);
      for (int i = 0; i < 8; i++) blk_bytes[56+i] = msg_bits[63-8*i -: 8];
      blk_fill = 6'd0;
      compress_blk();
      for (int i = 0; i < 8; i++) begin
        d.digest_word = hash_acc[i];
        d.digest_last = (i == 7);
        digest_q = {digest_q, d};
      end
      for (int i = 0; i < 8; i++) hash_acc[i] = IV[i];
      msg_bits = '0;
    end
  endtask

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Random gap length: mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // Directed table: known digests where they are standard
  typedef struct {
    sha_in_t  rq;
    bit       has_known;
    logic [31:0] known_h0;
  } row_t;
  row_t dir_tab [$];
  logic [31:0] known_q [$];

  sha_in_t rq_hold;

  // valid drops only for a gap, so back-to-back requests keep it high
  task automatic send_request(sha_in_t rq);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    hash_request(rq);
  endtask

  task automatic add_row(logic [7:0] b, bit p, bit e, bit k, logic [31:0] h0);
    row_t r;
    r.rq.data_byte = b; r.rq.byte_present = p; r.rq.message_end = e;
    r.has_known = k; r.known_h0 = h0;
    dir_tab = {dir_tab, r};
  endtask

  // Stimulus
  initial begin
    int nmsg, len;
    in_valid  = 1'b0;
    in_data   = '0;
    rst_n     = 1'b0;
    stim_done = 1'b0;
    mismatches = 0;
    for (int i = 0; i < 8; i++) hash_acc[i] = IV[i];
    blk_fill = '0;
    msg_bits = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message, "abc", idle item, extreme bytes, end item carrying a byte
    add_row(8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442);
    add_row(8'h61, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h62, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'h63, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b1, 1'b1, 32'hba7816bf);
    add_row(8'hff, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'hff, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'haa, 1'b1, 1'b1, 1'b0, '0);
    add_row(8'h55, 1'b1, 1'b1, 1'b0, '0);
    foreach (dir_tab[i]) begin
      if (dir_tab[i].has_known) known_q = {known_q, dir_tab[i].known_h0};
      send_request(dir_tab[i].rq);
    end

    // Tails at block boundaries: 56 with a separate end, 63 and 64 ending on a byte
    for (int i = 0; i < 3; i++) begin
      len = (i == 0) ? 56 : (i == 1) ? 63 : 64;
      for (int j = 0; j < len; j++) begin
        rq_hold.data_byte = 8'($urandom); rq_hold.byte_present = 1'b1;
        rq_hold.message_end = (j == len - 1) && (i != 0);
        send_request(rq_hold);
      end
      if (i == 0) begin
        rq_hold = '0; rq_hold.message_end = 1'b1;
        send_request(rq_hold);
      end
    end

    // Random short messages with stray idle items
    nmsg = 0;
    while (nmsg < 3) begin
      len = $urandom_range(0, 12);
      for (int j = 0; j < len; j++) begin
        rq_hold.data_byte = 8'($urandom);
        rq_hold.byte_present = ($urandom_range(0, 7) != 0);
        rq_hold.message_end = 1'b0;
        send_request(rq_hold);
      end
      rq_hold.data_byte = 8'($urandom);
      rq_hold.byte_present = ($urandom_range(0, 1) == 1);
      rq_hold.message_end = 1'b1;
      send_request(rq_hold);
      nmsg++;
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver stalls
  initial begin
    int g;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (g > 0) begin
        g--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) g = gap_len();
      end
    end
  end

  // Result check
  always @(posedge clk) begin
    sha_out_t exp_w;
    logic [31:0] h0;
    if (rst_n && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected digest word %h last %b", out_data.digest_word,
                   out_data.digest_last);
      end else begin
        exp_w = digest_q.pop_front();
        if (exp_w.digest_word !== out_data.digest_word ||
            exp_w.digest_last !== out_data.digest_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: exp %h/%b got %h/%b", exp_w.digest_word,
                     exp_w.digest_last, out_data.digest_word, out_data.digest_last);
        end
        // H0 of standard vectors read off directly
        if (digest_q.size() % 8 == 7 && known_q.size() > 0) begin
          h0 = known_q.pop_front();
          if (h0 !== out_data.digest_word) begin
            mismatches++;
            if (mismatches <= 10)
              $display("known H0 mismatch: exp %h got %h", h0, out_data.digest_word);
          end
        end
      end
    end
  end

  // End of run
  initial begin
    @(posedge clk);
    wait (stim_done);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0)
      $display("** sha256_byte_stream_hasher_unit: PASSED **");
    else
      $display("** sha256_byte_stream_hasher_unit: FAILED **");
    $finish;
  end

  // Timeout
  initial begin
    #20ms;
    $display("** sha256_byte_stream_hasher_unit: FAILED **");
    $finish;
  end

endmodule

>>> sha256_byte_stream_hasher_unit.f
hw/rtl/sha_pkg.sv
hw/rtl/sha_ctrl.sv
hw/rtl/sha_dpath.sv
hw/rtl/sha256_byte_stream_hasher_unit.sv
bench/tb.sv
